FILE: sv/wra_pkg.sv
`timescale 1ns / 1ps

package wra_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // Default width of the stored value
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Register reset values
  localparam logic [DATA_W-1:0] RST_RANGE_START = 16'd1;
  localparam logic [DATA_W-1:0] RST_RANGE_END   = 16'd12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [ERR_W-1:0] ERR_INEXACT  = 2'd2;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ASSIGN = 3'd0,
    FUNC_ADD    = 3'd1,
    FUNC_SUB    = 3'd2,
    FUNC_MUL    = 3'd3,
    FUNC_DIV    = 3'd4,
    FUNC_INC    = 3'd5,
    FUNC_DEC    = 3'd6,
    FUNC_NEG    = 3'd7
  } func_e;

endpackage

FILE: sv/wrapped_range_arithmetic.sv
`timescale 1ns / 1ps

// Wrapped range arithmetic: keeps one value inside [range_start, range_end].
// Input channel (in_valid_i / in_stall_o) carries func, operand, write_back;
// a word is taken when in_valid_i is high and in_stall_o is low. The block
// works on one word at a time and holds in_stall_o high until its result
// has been loaded into the output register.
// Output channel (out_valid_o / out_stall_i) carries result_value,
// previous_value and error_code, one result word per input word.
// Path from accept to out_valid_o, with W = min(VALUE_BITS, 16):
//   divide by zero: straight to the result; inexact divide: the divide only;
//   exact divide: the divide, then the floor modulo; every other operation: the floor modulo.
// The divide and the modulo share one restoring subtract/compare unit that
// retires one bit per cycle: W steps for the divide, W + 32 steps for the
// floor modulo of the exact result over the range size.
// A new word is taken the cycle after the result register is loaded.
// If the receiver stalls while a result is still held, the finished result
// waits inside the block and the input stays stalled.
// Reset: range_start = 1, range_end = 12, value = 1, both channels idle.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are to be issued
// only while the block is idle; writing range_start also loads the value.
module wrapped_range_arithmetic #(
  parameter int unsigned VALUE_BITS = wra_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration port
  input  logic                                 cfg_we_i,
  input  logic [wra_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [wra_pkg::DATA_W-1:0]           cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [wra_pkg::FUNC_W-1:0]           func_i,
  input  logic signed [wra_pkg::OPERAND_W-1:0] operand_i,
  input  logic                                 write_back_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [wra_pkg::DATA_W-1:0]           result_value_o,
  output logic [wra_pkg::DATA_W-1:0]           previous_value_o,
  output logic [wra_pkg::ERR_W-1:0]            error_code_o
);

  // Stored width, widths of the exact result, shift register and remainder
  localparam int unsigned VW = (VALUE_BITS < wra_pkg::DATA_W) ? VALUE_BITS : wra_pkg::DATA_W;
  localparam int unsigned OW = wra_pkg::OPERAND_W;
  localparam int unsigned YW = VW + OW;
  localparam int unsigned XW = YW + 1;
  localparam int unsigned DW = OW + 1;
  localparam int unsigned CW = $clog2(YW + 1);

  localparam logic signed [XW-1:0] ONE_X = XW'(1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PREP = 8'b0000_0010,
    ST_DIVI = 8'b0000_0100,
    ST_DCHK = 8'b0000_1000,
    ST_OFFS = 8'b0001_0000,
    ST_MODI = 8'b0010_0000,
    ST_WRAP = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  // Control state
  state_e                  state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  logic [VW-1:0]           start_q, start_d;
  logic [VW-1:0]           end_q, end_d;
  logic [VW-1:0]           cur_q, cur_d;

  // Item payload and datapath
  wra_pkg::func_e          func_q, func_d;
  logic signed [OW-1:0]    op_q, op_d;
  logic                    wb_q, wb_d;
  logic [VW-1:0]           prev_q, prev_d;
  logic signed [XW-1:0]    x_q, x_d;
  logic [YW-1:0]           sh_q, sh_d;
  logic [DW-1:0]           rem_q, rem_d;
  logic [DW-1:0]           dvs_q, dvs_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic [wra_pkg::ERR_W-1:0] err_q, err_d;
  logic [VW-1:0]           res_q, res_d;
  logic [VW-1:0]           out_res_q, out_res_d;
  logic [VW-1:0]           out_prev_q, out_prev_d;
  logic [wra_pkg::ERR_W-1:0] out_err_q, out_err_d;

  // Range size; an inverted range collapses to range_start
  logic [VW-1:0] end_eff;
  logic [VW:0]   size_w;
  assign end_eff = (end_q < start_q) ? start_q : end_q;
  assign size_w  = {1'b0, end_eff} - {1'b0, start_q} + (VW+1)'(1);

  // Exact result of the non-dividing operations
  logic signed [XW-1:0] cur_s, op_s, end_s, prod_s, prep_x;
  assign cur_s  = XW'($signed({1'b0, cur_q}));
  assign end_s  = XW'($signed({1'b0, end_q}));
  assign op_s   = XW'(op_q);
  assign prod_s = $signed({1'b0, cur_q}) * op_q;

  always_comb begin
    unique case (func_q)
      wra_pkg::FUNC_ASSIGN: prep_x = op_s;
      wra_pkg::FUNC_ADD:    prep_x = cur_s + op_s;
      wra_pkg::FUNC_SUB:    prep_x = cur_s - op_s;
      wra_pkg::FUNC_MUL:    prep_x = prod_s;
      wra_pkg::FUNC_INC:    prep_x = cur_s + ONE_X;
      wra_pkg::FUNC_DEC:    prep_x = cur_s - ONE_X;
      wra_pkg::FUNC_NEG:    prep_x = end_s - cur_s;
      default:              prep_x = cur_s;
    endcase
  end

  // Shared restoring step: shift in one dividend bit, subtract if it fits
  logic [DW-1:0] step_shift;
  logic [DW:0]   step_trial;
  logic          step_take;
  logic [DW-1:0] step_rem;
  logic [YW-1:0] step_sh;
  assign step_shift = {rem_q[DW-2:0], sh_q[YW-1]};
  assign step_trial = {1'b0, step_shift} - {1'b0, dvs_q};
  assign step_take  = ~step_trial[DW];
  assign step_rem   = step_take ? step_trial[DW-1:0] : step_shift;
  assign step_sh    = {sh_q[YW-2:0], step_take};

  // Divide helpers: operand magnitude, signed quotient
  logic [OW-1:0]        op_abs;
  logic signed [XW-1:0] quo_x;
  assign op_abs = op_q[OW-1] ? -op_q : op_q;
  assign quo_x  = XW'(sh_q[VW-1:0]);

  // Offset from range_start and its magnitude
  logic signed [XW-1:0] y_s;
  logic [XW-1:0]        y_abs;
  assign y_s   = x_q - XW'($signed({1'b0, start_q}));
  assign y_abs = y_s[XW-1] ? -y_s : y_s;

  // Floor-modulo fix-up and final add of range_start
  logic [VW:0] rem_m, mod_m, wrap_sum;
  assign rem_m    = rem_q[VW:0];
  assign mod_m    = (neg_q && (rem_m != '0)) ? (size_w - rem_m) : rem_m;
  assign wrap_sum = {1'b0, start_q} + mod_m;

  logic last_step;
  assign last_step = (cnt_q == CW'(1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    start_d     = start_q;
    end_d       = end_q;
    cur_d       = cur_q;
    func_d      = func_q;
    op_d        = op_q;
    wb_d        = wb_q;
    prev_d      = prev_q;
    x_d         = x_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    err_d       = err_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    out_prev_d  = out_prev_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = wra_pkg::func_e'(func_i);
          op_d    = operand_i;
          wb_d    = write_back_i;
          prev_d  = cur_q;
          err_d   = wra_pkg::ERR_NONE;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (func_q == wra_pkg::FUNC_DIV) begin
          if (op_q == '0) begin
            err_d   = wra_pkg::ERR_DIV_ZERO;
            res_d   = cur_q;
            state_d = ST_FIN;
          end else begin
            sh_d    = {cur_q, (YW-VW)'(0)};
            rem_d   = '0;
            dvs_d   = DW'(op_abs);
            cnt_d   = CW'(VW);
            state_d = ST_DIVI;
          end
        end else begin
          x_d     = prep_x;
          state_d = ST_OFFS;
        end
      end
      ST_DIVI: begin
        rem_d = step_rem;
        sh_d  = step_sh;
        cnt_d = cnt_q - CW'(1);
        if (last_step) begin
          state_d = ST_DCHK;
        end
      end
      ST_DCHK: begin
        // nonzero remainder: not exact
        if (rem_q != '0) begin
          err_d   = wra_pkg::ERR_INEXACT;
          res_d   = cur_q;
          state_d = ST_FIN;
        end else begin
          x_d     = op_q[OW-1] ? -quo_x : quo_x;
          state_d = ST_OFFS;
        end
      end
      ST_OFFS: begin
        sh_d    = y_abs[YW-1:0];
        neg_d   = y_s[XW-1];
        rem_d   = '0;
        dvs_d   = DW'(size_w);
        cnt_d   = CW'(YW);
        state_d = ST_MODI;
      end
      ST_MODI: begin
        rem_d = step_rem;
        sh_d  = step_sh;
        cnt_d = cnt_q - CW'(1);
        if (last_step) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        res_d   = wrap_sum[VW-1:0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // load the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_prev_d  = prev_q;
          out_err_d   = err_q;
          if (wb_q && (err_q == wra_pkg::ERR_NONE)) begin
            cur_d = res_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Register writes, to be issued by the host only while idle; the block leaves this unchecked
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wra_pkg::REG_RANGE_START: begin
          start_d = cfg_wdata_i[VW-1:0];
          cur_d   = cfg_wdata_i[VW-1:0];
        end
        wra_pkg::REG_RANGE_END: begin
          end_d = cfg_wdata_i[VW-1:0];
        end
        default: begin
          end_d = end_q;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      start_q     <= wra_pkg::RST_RANGE_START[VW-1:0];
      end_q       <= wra_pkg::RST_RANGE_END[VW-1:0];
      cur_q       <= wra_pkg::RST_RANGE_START[VW-1:0];
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
      end_q       <= end_d;
      cur_q       <= cur_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    op_q       <= op_d;
    wb_q       <= wb_d;
    prev_q     <= prev_d;
    x_q        <= x_d;
    sh_q       <= sh_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    err_q      <= err_d;
    res_q      <= res_d;
    out_res_q  <= out_res_d;
    out_prev_q <= out_prev_d;
    out_err_q  <= out_err_d;
  end

  // Ports
  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_value_o   = wra_pkg::DATA_W'(out_res_q);
  assign previous_value_o = wra_pkg::DATA_W'(out_prev_q);
  assign error_code_o     = out_err_q;

endmodule

FILE: sv/wra_checker.sv
`timescale 1ns / 1ps

module wra_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_we_i,
  input logic [wra_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input logic [wra_pkg::DATA_W-1:0]           cfg_wdata_i,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [wra_pkg::FUNC_W-1:0]           func_i,
  input logic signed [wra_pkg::OPERAND_W-1:0] operand_i,
  input logic                                 write_back_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [wra_pkg::DATA_W-1:0]           result_value_o,
  input logic [wra_pkg::DATA_W-1:0]           previous_value_o,
  input logic [wra_pkg::ERR_W-1:0]            error_code_o
);

  // A held result word stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A held result word keeps its value
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_value_o) && $stable(previous_value_o)
      && $stable(error_code_o))
    else $error("result word changed while stalled");

  // One word at a time: busy right after an accept
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while busy");

  // On an error the reported result is the unchanged value
  a_err_keeps_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != wra_pkg::ERR_NONE) |->
      result_value_o == previous_value_o)
    else $error("erroring word reports a changed value");

  // A word leaves the block only after an accepted input
  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_stall_o |=> !out_valid_o)
    else $error("result word appeared with no input in flight");

endmodule

bind wrapped_range_arithmetic wra_checker u_wra_checker (.*);

FILE: dv/tb_wrapped_range_arithmetic.sv
`timescale 1ns / 1ps

module tb_wrapped_range_arithmetic;
  import wra_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned N_PHASES        = 14;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned MAX_PRINTED     = 40;

  // one expected result word
  typedef struct {
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] prev;
    logic [ERR_W-1:0]  err;
  } range_word_t;

  // one pending operation or register write
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
    func_e                fn;
    logic signed [31:0]   opnd;
    logic                 wb;
  } op_entry_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i    = REG_RANGE_START;
  logic [DATA_W-1:0]       cfg_wdata_i  = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [FUNC_W-1:0]       func_i       = FUNC_ASSIGN;
  logic signed [OPERAND_W-1:0] operand_i = '0;
  logic                    write_back_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic [DATA_W-1:0]       result_value_o;
  logic [DATA_W-1:0]       previous_value_o;
  logic [ERR_W-1:0]        error_code_o;

  wrapped_range_arithmetic u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .operand_i       (operand_i),
    .write_back_i    (write_back_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_o  (result_value_o),
    .previous_value_o(previous_value_o),
    .error_code_o    (error_code_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  op_entry_t   op_queue[$];
  range_word_t wrapped_results_q[$];

  // stimulus-side copy of the block state, used to aim exact divides
  logic [DATA_W-1:0] gen_start = RST_RANGE_START;
  logic [DATA_W-1:0] gen_end   = RST_RANGE_END;
  logic [DATA_W-1:0] gen_value = RST_RANGE_START;

  // checker-side copy of the block state
  logic [DATA_W-1:0] pred_start, pred_end, pred_value;

  int unsigned n_fail, n_sent, n_results, n_cfg, n_div_zero, n_inexact, n_holds;

  // floor modulo of x into [lo_r, hi_r]; inverted range collapses to lo_r
  function automatic logic [DATA_W-1:0] wrap_value(input logic [DATA_W-1:0] lo_r,
                                                   input logic [DATA_W-1:0] hi_r,
                                                   input longint x);
    longint lo, hi, span, m, sum;
    lo = lo_r;
    hi = hi_r;
    if (hi < lo) hi = lo;
    span = hi - lo + 1;
    m = (x - lo) % span;
    if (m < 0) m += span;
    sum = lo + m;
    return sum[DATA_W-1:0];
  endfunction

  // result of one word and the value left stored afterwards
  function automatic void range_arith_model(input logic [DATA_W-1:0] lo_r,
                                            input logic [DATA_W-1:0] hi_r,
                                            input logic [DATA_W-1:0] cur_r,
                                            input func_e fn,
                                            input logic signed [31:0] opnd,
                                            input logic wb,
                                            output range_word_t w,
                                            output logic [DATA_W-1:0] next_v);
    longint cur, op, hi_v;
    cur  = cur_r;
    op   = opnd;
    hi_v = hi_r;
    w.prev = cur_r;
    w.res  = cur_r;
    w.err  = ERR_NONE;
    case (fn)
      FUNC_ASSIGN: w.res = wrap_value(lo_r, hi_r, op);
      FUNC_ADD:    w.res = wrap_value(lo_r, hi_r, cur + op);
      FUNC_SUB:    w.res = wrap_value(lo_r, hi_r, cur - op);
      FUNC_MUL:    w.res = wrap_value(lo_r, hi_r, cur * op);
      FUNC_DIV: begin
        if (op == 0) w.err = ERR_DIV_ZERO;
        else if (cur % op != 0) w.err = ERR_INEXACT;
        else w.res = wrap_value(lo_r, hi_r, cur / op);
      end
      FUNC_INC:    w.res = wrap_value(lo_r, hi_r, cur + 1);
      FUNC_DEC:    w.res = wrap_value(lo_r, hi_r, cur - 1);
      default:     w.res = wrap_value(lo_r, hi_r, hi_v - cur);
    endcase
    next_v = (w.err == ERR_NONE && wb) ? w.res : cur_r;
  endfunction

  // idle draw with occasional stretches of no idling
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_fail++;
    if (n_fail <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_op(input func_e fn, input logic signed [31:0] v, input logic wb);
    op_entry_t e;
    range_word_t w;
    logic [DATA_W-1:0] nv;
    e.is_cfg = 1'b0;
    e.idx    = REG_RANGE_START;
    e.data   = '0;
    e.fn     = fn;
    e.opnd   = v;
    e.wb     = wb;
    range_arith_model(gen_start, gen_end, gen_value, fn, v, wb, w, nv);
    gen_value = nv;
    op_queue.push_back(e);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    op_entry_t e;
    e.is_cfg = 1'b1;
    e.idx    = idx;
    e.data   = d;
    e.fn     = FUNC_ASSIGN;
    e.opnd   = '0;
    e.wb     = 1'b0;
    if (idx == REG_RANGE_START) begin
      gen_start = d;
      gen_value = d;
    end else begin
      gen_end = d;
    end
    op_queue.push_back(e);
  endtask

  // both registers, in random order
  task automatic set_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    if ($urandom_range(0, 1)) begin
      add_cfg(REG_RANGE_START, lo);
      add_cfg(REG_RANGE_END, hi);
    end else begin
      add_cfg(REG_RANGE_END, hi);
      add_cfg(REG_RANGE_START, lo);
    end
  endtask

  // nonzero operand that divides v exactly (any operand when v is zero)
  function automatic logic signed [31:0] pick_divisor(input logic [DATA_W-1:0] v);
    int unsigned d;
    logic signed [31:0] q;
    if (v == 0) return $urandom;
    case ($urandom_range(0, 3))
      0: q = {16'b0, v};
      1: q = 1;
      default: begin
        d = $urandom_range(2, 12);
        while (v % d != 0) d--;
        q = d;
      end
    endcase
    if ($urandom_range(0, 1)) q = -q;
    return q;
  endfunction

  function automatic logic signed [31:0] pick_operand(input logic [DATA_W-1:0] lo,
                                                      input logic [DATA_W-1:0] hi);
    int unsigned span;
    span = (hi >= lo) ? (hi - lo + 1) : 1;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 40) - 20;
      1, 2: return $urandom;
      3: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      4: return {16'b0, lo} + $urandom_range(0, 3 * span) - span;
      default: return 32'd0 - $urandom_range(0, 70000);
    endcase
  endfunction

  task automatic add_random_op();
    func_e fn;
    logic signed [31:0] v;
    fn = func_e'($urandom_range(0, 7));
    if (fn == FUNC_DIV && $urandom_range(0, 1)) v = pick_divisor(gen_value);
    else v = pick_operand(gen_start, gen_end);
    add_op(fn, v, $urandom_range(0, 3) != 0);
  endtask

  task automatic fill_op_queue();
    int unsigned a, b, kind;
    // reset range 1..12: extremes, every operation, both write_back values
    add_op(FUNC_ASSIGN, 32'h8000_0000, 1'b1);
    add_op(FUNC_ASSIGN, 32'h7FFF_FFFF, 1'b1);
    add_op(FUNC_ASSIGN, 32'h0000_0000, 1'b0);
    add_op(FUNC_ADD, 5, 1'b1);
    add_op(FUNC_SUB, -7, 1'b1);
    add_op(FUNC_MUL, 1000, 1'b1);
    add_op(FUNC_MUL, 32'h8000_0000, 1'b0);
    add_op(FUNC_DIV, 0, 1'b1);
    add_op(FUNC_DIV, pick_divisor(gen_value), 1'b1);
    add_op(FUNC_DIV, 7, 1'b1);
    add_op(FUNC_INC, $urandom, 1'b1);
    add_op(FUNC_DEC, $urandom, 1'b1);
    add_op(FUNC_NEG, $urandom, 1'b1);
    add_op(FUNC_INC, 0, 1'b0);
    add_op(FUNC_DEC, 0, 1'b0);
    add_op(FUNC_NEG, 0, 1'b0);
    // stale value after shrinking the range end; erroring divides keep it
    set_range(16'h0000, 16'hFFFF);
    add_op(FUNC_ASSIGN, 60000, 1'b1);
    add_cfg(REG_RANGE_END, 16'd12);
    add_op(FUNC_DIV, 0, 1'b1);
    add_op(FUNC_DIV, 7, 1'b1);
    add_op(FUNC_ADD, 1, 1'b0);
    // zero divides exactly by anything nonzero
    add_op(FUNC_ASSIGN, 0, 1'b1);
    add_op(FUNC_DIV, -5, 1'b1);
    // inverted range collapses to range_start
    set_range(16'd100, 16'd50);
    add_op(FUNC_ADD, 12345, 1'b1);
    add_op(FUNC_NEG, 0, 1'b1);

    // random phases, each with its own range setting
    for (int p = 0; p < N_PHASES; p++) begin
      kind = (p < 6) ? p : $urandom_range(0, 5);
      case (kind)
        0: set_range(16'h0000, 16'hFFFF);
        1: set_range(16'hFFFF, 16'hFFFF);
        2: set_range(16'h0000, 16'h0000);
        3: begin
          a = $urandom_range(1, 65535);
          b = $urandom_range(0, a - 1);
          set_range(a[15:0], b[15:0]);
        end
        4: begin
          a = $urandom_range(0, 65535);
          b = a + $urandom_range(0, 20);
          if (b > 65535) b = 65535;
          set_range(a[15:0], b[15:0]);
        end
        default: begin
          // end only: the stored value may be left outside the range
          a = $urandom_range(0, 65535);
          add_cfg(REG_RANGE_END, a[15:0]);
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) add_random_op();
    end
  endtask

  // ------------------------------------------------------------------ driver
  op_entry_t         drv_entry, drv_head;
  range_word_t       drv_w;
  logic [DATA_W-1:0] drv_next;
  int unsigned       drv_gap;
  bit                drv_calm, drv_offer, drv_we;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      func_i       <= FUNC_ASSIGN;
      operand_i    <= '0;
      write_back_i <= 1'b0;
      cfg_we_i     <= 1'b0;
      cfg_idx_i    <= REG_RANGE_START;
      cfg_wdata_i  <= '0;
      pred_start   = RST_RANGE_START;
      pred_end     = RST_RANGE_END;
      pred_value   = RST_RANGE_START;
      drv_gap      = 0;
    end else begin
      drv_offer = in_valid_i;
      drv_we    = 1'b0;
      // word taken: predict its result
      if (in_valid_i && !in_stall_o) begin
        range_arith_model(pred_start, pred_end, pred_value, drv_entry.fn, drv_entry.opnd,
                          drv_entry.wb, drv_w, drv_next);
        pred_value = drv_next;
        wrapped_results_q.push_back(drv_w);
        n_sent++;
        drv_offer = 1'b0;
        drv_gap   = draw_wait(drv_calm);
      end
      if (!drv_offer) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (op_queue.size() > 0) begin
          drv_head = op_queue[0];
          if (drv_head.is_cfg) begin
            // register writes only once every result is back
            if (wrapped_results_q.size() == 0) begin
              void'(op_queue.pop_front());
              drv_we = 1'b1;
              cfg_idx_i   <= drv_head.idx;
              cfg_wdata_i <= drv_head.data;
              n_cfg++;
              if (drv_head.idx == REG_RANGE_START) begin
                pred_start = drv_head.data;
                pred_value = drv_head.data;
              end else begin
                pred_end = drv_head.data;
              end
            end
          end else begin
            drv_entry = op_queue.pop_front();
            drv_offer = 1'b1;
            func_i       <= drv_entry.fn;
            operand_i    <= drv_entry.opnd;
            write_back_i <= drv_entry.wb;
          end
        end
      end
      in_valid_i <= drv_offer;
      cfg_we_i   <= drv_we;
    end
  end

  // ----------------------------------------------------------------- monitor
  range_word_t mon_w;
  int unsigned mon_wait, hold_left;
  bit          mon_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_wait  = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (wrapped_results_q.size() == 0) begin
          report_mismatch("result word with none pending", result_value_o, 0);
        end else begin
          mon_w = wrapped_results_q.pop_front();
          if (result_value_o !== mon_w.res)
            report_mismatch("result_value", result_value_o, mon_w.res);
          if (previous_value_o !== mon_w.prev)
            report_mismatch("previous_value", previous_value_o, mon_w.prev);
          if (error_code_o !== mon_w.err)
            report_mismatch("error_code", error_code_o, mon_w.err);
          if (mon_w.err == ERR_DIV_ZERO) n_div_zero++;
          if (mon_w.err == ERR_INEXACT) n_inexact++;
        end
        n_results++;
        mon_wait = draw_wait(mon_calm);
        // long hold-off so the block backs up onto its input
        if (n_results == 250 || n_results == 900) begin
          hold_left = HOLD_CYCLES;
          n_holds++;
        end
      end else if (out_valid_o && mon_wait > 0) begin
        mon_wait--;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (mon_wait > 0);
    end
  end

  // ---------------------------------------------------------------- watchdog
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------ run control
  initial begin
    fill_op_queue();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (op_queue.size() != 0 || in_valid_i) @(negedge clk_i);
    while (wrapped_results_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d words against %0d results over %0d register writes.",
             n_sent, n_results, n_cfg);
    $display("Divide-by-zero: %0d, inexact divide: %0d, long receiver holds: %0d.",
             n_div_zero, n_inexact, n_holds);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
